[rtl/bsrg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsrg_pkg
// Shared types and constants of the banker's admission unit.
// ----------------------------------------------------------------------------
package bsrg_pkg;

	localparam int unsigned MAX_PROCS = 16;
	localparam int unsigned MAX_RES   = 5;
	localparam int unsigned PID_W     = $clog2(MAX_PROCS);
	localparam int unsigned RID_W     = 3;
	localparam int unsigned WORK_W    = 13;
	localparam int unsigned NPROC_W   = 5;
	localparam int unsigned NRES_W    = 3;
	localparam int unsigned ROW_W     = 8 * MAX_RES;
	localparam logic [WORK_W-1:0] WORK_MAX = {WORK_W{1'b1}};

	// item types
	localparam logic [1:0] T_LOAD_PROC  = 2'd0;
	localparam logic [1:0] T_LOAD_AVAIL = 2'd1;
	localparam logic [1:0] T_REQUEST    = 2'd2;

	// result codes
	localparam logic [2:0] ST_LOADED   = 3'd0;
	localparam logic [2:0] ST_GRANTED  = 3'd1;
	localparam logic [2:0] ST_EXCEEDS  = 3'd2;
	localparam logic [2:0] ST_WAIT     = 3'd3;
	localparam logic [2:0] ST_UNSAFE   = 3'd4;
	localparam logic [2:0] ST_BADIDX   = 3'd5;
	localparam logic [2:0] ST_CLAIMLOW = 3'd6;

	// config register indexes
	localparam logic [NRES_W-1:0] CFG_NPROC = 3'd0;
	localparam logic [NRES_W-1:0] CFG_NRES  = 3'd1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD_RD,
		S_LOAD_WR,
		S_REQ_RD,
		S_REQ_CHK,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_ROLLBACK,
		S_DONE
	} state_t;

	// request to the row memories
	typedef struct packed {
		logic             we;
		logic [PID_W-1:0] addr;
		logic [ROW_W-1:0] alloc_wd;
		logic [ROW_W-1:0] need_wd;
	} row_req_t;

endpackage : bsrg_pkg
`default_nettype wire

[rtl/bsrg_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsrg_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bsrg_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// read first port, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule : bsrg_ram
`default_nettype wire

[rtl/bsrg_rows.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsrg_rows
// Per-process allocation and need rows, one memory each, shared address.
// ----------------------------------------------------------------------------
module bsrg_rows
	import bsrg_pkg::*;
(
	input  wire logic             clk,
	input  wire row_req_t         req,
	output logic      [ROW_W-1:0] alloc_rd,
	output logic      [ROW_W-1:0] need_rd
);
	// allocation rows
	bsrg_ram #(.WIDTH(ROW_W), .DEPTH(MAX_PROCS)) u_alloc (
		.clk  (clk),
		.we   (req.we),
		.addr (req.addr),
		.wdata(req.alloc_wd),
		.rdata(alloc_rd)
	);

	// need rows
	bsrg_ram #(.WIDTH(ROW_W), .DEPTH(MAX_PROCS)) u_need (
		.clk  (clk),
		.we   (req.we),
		.addr (req.addr),
		.wdata(req.need_wd),
		.rdata(need_rd)
	);
endmodule : bsrg_rows
`default_nettype wire

[rtl/bankers_safe_request_grant.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bankers_safe_request_grant
// Banker's algorithm admission: loads, requests and safety scan over rows
// held in a pair of synchronous memories.
// ----------------------------------------------------------------------------
// channel | signals                          | transfer when
// in      | in_valid/in_ready, req_type..req_4| in_valid & in_ready
// out     | out_valid/out_ready, status      | out_valid & out_ready
// cfg     | cfg_we, cfg_index, cfg_data      | cfg_we
//
// One item at a time. A process load reads then writes its row; available
// loads and bad items go straight to the result; a rejected request reads
// and checks the requester row. A granted request runs a safety scan of up
// to N passes over N rows, each row a memory read plus check; a rollback
// reuses the load path. The single row memory port paces the scan.
// Result sits in an output register; a stall on out holds the next item.
// Reset clears control state; memory contents are undefined until loaded.
// ----------------------------------------------------------------------------
module bankers_safe_request_grant
	import bsrg_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        req_type,
	input  wire logic [3:0]        process_id,
	input  wire logic [2:0]        resource_id,
	input  wire logic [7:0]        first_value,
	input  wire logic [7:0]        second_value,
	input  wire logic [7:0]        req_0,
	input  wire logic [7:0]        req_1,
	input  wire logic [7:0]        req_2,
	input  wire logic [7:0]        req_3,
	input  wire logic [7:0]        req_4,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic      [2:0]        status,
	input  wire logic              cfg_we,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [4:0]        cfg_data
);
	state_t state_q, state_d;

	logic [NPROC_W-1:0] nproc_q;
	logic [NRES_W-1:0]  nres_q;
	logic [PID_W-1:0]   n_last;     // processes in use minus one
	logic [MAX_RES-1:0] res_en;     // resource types in use

	logic [PID_W-1:0]   pid_q;
	logic [RID_W-1:0]   rid_q;
	logic [7:0]         a_q, b_q;
	logic [7:0]         rq_q [MAX_RES];
	logic [7:0]         avail_q [MAX_RES];
	logic [WORK_W-1:0]  work_q [MAX_RES];
	logic [MAX_PROCS-1:0] fin_q;
	logic [PID_W-1:0]   row_q;
	logic               prog_q;
	logic [2:0]         status_q;
	logic               out_valid_q;

	// rollback flag: load path reused to restore the requester row
	logic rb_q;

	row_req_t           rreq;
	logic [ROW_W-1:0]   alloc_rd, need_rd;

	bsrg_rows u_rows (
		.clk     (clk),
		.req     (rreq),
		.alloc_rd(alloc_rd),
		.need_rd (need_rd)
	);

	// clamped register values
	always_comb begin
		if (nproc_q == '0) n_last = '0;
		else if (nproc_q >= NPROC_W'(MAX_PROCS)) n_last = PID_W'(MAX_PROCS - 1);
		else n_last = PID_W'(nproc_q - 1'b1);
		for (int j = 0; j < MAX_RES; j++) begin
			res_en[j] = (NRES_W'(j) < nres_q) || (j == 0);
		end
	end

	// per-resource comparisons on the read row
	logic [MAX_RES-1:0] exceed_need, exceed_avail, fits;
	always_comb begin
		for (int j = 0; j < MAX_RES; j++) begin
			exceed_need[j]  = res_en[j] && (rq_q[j] > need_rd[8*j +: 8]);
			exceed_avail[j] = res_en[j] && (rq_q[j] > avail_q[j]);
			fits[j]         = !res_en[j] || ({5'd0, need_rd[8*j +: 8]} <= work_q[j]);
		end
	end

	assign in_ready  = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign status    = status_q;

	wire in_xfer   = in_valid && in_ready;
	wire last_row  = (row_q == n_last);
	wire fit_now   = !fin_q[row_q] && &fits;

	function automatic logic done_all_next(input logic [MAX_PROCS-1:0] f,
		input logic [PID_W-1:0] r, input logic [PID_W-1:0] nl);
		logic [MAX_PROCS-1:0] g;
		logic ok;
		g = f;
		g[r] = 1'b1;
		ok = 1'b1;
		for (int i = 0; i < MAX_PROCS; i++) begin
			if (PID_W'(i) <= nl && !g[i]) ok = 1'b0;
		end
		return ok;
	endfunction

	// next state and memory access
	always_comb begin
		state_d       = state_q;
		rreq.we       = 1'b0;
		rreq.addr     = pid_q;
		rreq.alloc_wd = alloc_rd;
		rreq.need_wd  = need_rd;
		unique case (state_q)
			S_IDLE: begin
				rreq.addr = process_id;
				if (in_xfer) begin
					if (req_type == T_LOAD_PROC && resource_id < RID_W'(MAX_RES))
						state_d = S_LOAD_RD;
					else if (req_type == T_REQUEST && {1'b0, process_id} <= {1'b0, n_last})
						state_d = S_REQ_RD;
					else
						state_d = S_DONE;
				end
			end
			S_LOAD_RD: state_d = S_LOAD_WR;
			S_LOAD_WR: begin
				rreq.we = 1'b1;
				for (int j = 0; j < MAX_RES; j++) begin
					if (rb_q) begin
						// undo the tentative grant on the requester row
						if (res_en[j]) begin
							rreq.alloc_wd[8*j +: 8] = 8'(alloc_rd[8*j +: 8] - rq_q[j]);
							rreq.need_wd[8*j +: 8]  = 8'(need_rd[8*j +: 8] + rq_q[j]);
						end
					end else if (RID_W'(j) == rid_q) begin
						rreq.alloc_wd[8*j +: 8] = a_q;
						rreq.need_wd[8*j +: 8]  = (b_q >= a_q) ? 8'(b_q - a_q) : 8'd0;
					end
				end
				state_d = S_DONE;
			end
			S_REQ_RD: state_d = S_REQ_CHK;
			S_REQ_CHK: begin
				if (|exceed_need || |exceed_avail) begin
					state_d = S_DONE;
				end else begin
					// tentative grant written back
					rreq.we = 1'b1;
					for (int j = 0; j < MAX_RES; j++) begin
						if (res_en[j]) begin
							rreq.alloc_wd[8*j +: 8] = 8'(alloc_rd[8*j +: 8] + rq_q[j]);
							rreq.need_wd[8*j +: 8]  = 8'(need_rd[8*j +: 8] - rq_q[j]);
						end
					end
					state_d = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				rreq.addr = row_q;
				state_d   = S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				if (fit_now && done_all_next(fin_q, row_q, n_last)) begin
					state_d = S_DONE;
				end else if (last_row && !(prog_q || fit_now)) begin
					state_d = S_ROLLBACK;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_ROLLBACK: begin
				// undo the grant on the requesting row, read again through the load path
				state_d = S_LOAD_RD;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			nproc_q     <= NPROC_W'(1);
			nres_q      <= NRES_W'(1);
			out_valid_q <= 1'b0;
			fin_q       <= '0;
			prog_q      <= 1'b0;
			row_q       <= '0;
			rb_q        <= 1'b0;
			status_q    <= ST_LOADED;
			for (int j = 0; j < MAX_RES; j++) work_q[j] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we && cfg_index == CFG_NPROC) nproc_q <= cfg_data;
			if (cfg_we && cfg_index == CFG_NRES)  nres_q  <= cfg_data[NRES_W-1:0];
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					rb_q <= 1'b0;
					if (in_xfer) begin
						status_q <= (req_type == T_LOAD_AVAIL
							&& resource_id < RID_W'(MAX_RES)) ? ST_LOADED : ST_BADIDX;
					end
				end
				S_LOAD_WR: begin
					if (rb_q) status_q <= ST_UNSAFE;
					else status_q <= (b_q >= a_q) ? ST_LOADED : ST_CLAIMLOW;
				end
				S_REQ_CHK: begin
					fin_q  <= '0;
					row_q  <= '0;
					prog_q <= 1'b0;
					if (|exceed_need) status_q <= ST_EXCEEDS;
					else if (|exceed_avail) status_q <= ST_WAIT;
					else begin
						for (int j = 0; j < MAX_RES; j++)
							work_q[j] <= WORK_W'(8'(avail_q[j] - (res_en[j] ? rq_q[j] : 8'd0)));
					end
				end
				S_SCAN_CHK: begin
					if (fit_now) begin
						fin_q[row_q] <= 1'b1;
						for (int j = 0; j < MAX_RES; j++) begin
							if (res_en[j]) begin
								if ({1'b0, work_q[j]} + {6'd0, alloc_rd[8*j +: 8]} > {1'b0, WORK_MAX})
									work_q[j] <= WORK_MAX;
								else
									work_q[j] <= WORK_W'(work_q[j] + {5'd0, alloc_rd[8*j +: 8]});
							end
						end
						status_q <= ST_GRANTED;
					end
					// progress flag restarts with each pass
					prog_q <= !last_row && (prog_q || fit_now);
					row_q  <= last_row ? '0 : row_q + 1'b1;
				end
				S_ROLLBACK: rb_q <= 1'b1;
				S_DONE: out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// item payload and available counts
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pid_q  <= process_id;
			rid_q  <= resource_id;
			a_q    <= first_value;
			b_q    <= second_value;
			rq_q[0] <= req_0;
			rq_q[1] <= req_1;
			rq_q[2] <= req_2;
			rq_q[3] <= req_3;
			rq_q[4] <= req_4;
			if (req_type == T_LOAD_AVAIL && resource_id < RID_W'(MAX_RES))
				avail_q[resource_id] <= first_value;
		end
		if (state_q == S_REQ_CHK && !(|exceed_need || |exceed_avail)) begin
			for (int j = 0; j < MAX_RES; j++)
				if (res_en[j]) avail_q[j] <= 8'(avail_q[j] - rq_q[j]);
		end
		if (state_q == S_LOAD_WR && rb_q) begin
			for (int j = 0; j < MAX_RES; j++)
				if (res_en[j]) avail_q[j] <= 8'(avail_q[j] + rq_q[j]);
		end
	end

`ifndef SYNTHESIS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result changed while stalled");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !in_ready)
		else $error("item accepted while busy");
	a_fin_subset: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN_RD && $past(state_q) == S_REQ_CHK |-> fin_q == '0)
		else $error("scan started with stale finished flags");
`endif
endmodule : bankers_safe_request_grant
`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the banker's admission unit. Loads every row and
// available count first, then runs directed and random loads and requests
// under several process and resource counts. A built-in predictor of the
// admission and safety scan gives the expected status for each transfer.
// ----------------------------------------------------------------------------
module tb;
	import bsrg_pkg::*;

	localparam logic [1:0] T_UNKNOWN = 2'd3;
	localparam int IDLE_LIMIT = 20000;

	typedef struct {
		logic [1:0] kind;
		logic [3:0] pid;
		logic [2:0] rid;
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] rq[MAX_RES];
	} item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] req_type = '0;
	logic [3:0] process_id = '0;
	logic [2:0] resource_id = '0;
	logic [7:0] first_value = '0, second_value = '0;
	logic [7:0] req_0 = '0, req_1 = '0, req_2 = '0, req_3 = '0, req_4 = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] status;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [4:0] cfg_data = '0;

	// predictor state
	logic [7:0] alloc_m[MAX_PROCS*MAX_RES];
	logic [7:0] need_m[MAX_PROCS*MAX_RES];
	logic [7:0] avail_m[MAX_RES];
	int unsigned nproc_reg = 1, nres_reg = 1;

	logic [2:0] status_q[$];
	int errors = 0;
	int idle_cycles = 0;
	bit calm = 1'b0;
	int out_stall = 0;

	bankers_safe_request_grant dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic int unsigned procs_used();
		return (nproc_reg < 1) ? 1 : (nproc_reg > MAX_PROCS) ? MAX_PROCS : nproc_reg;
	endfunction

	function automatic int unsigned res_used();
		return (nres_reg < 1) ? 1 : (nres_reg > MAX_RES) ? MAX_RES : nres_reg;
	endfunction

	// safety scan over the processes in use
	function automatic bit all_can_finish(int unsigned n, int unsigned m);
		logic [12:0] work[MAX_RES];
		bit fin[MAX_PROCS];
		int unsigned done;
		int unsigned w;
		bit prog, fits;
		done = 0;
		for (int j = 0; j < m; j++) work[j] = 13'(avail_m[j]);
		for (int i = 0; i < MAX_PROCS; i++) fin[i] = 1'b0;
		while (done < n) begin
			prog = 1'b0;
			for (int i = 0; i < n; i++) begin
				if (fin[i]) continue;
				fits = 1'b1;
				for (int j = 0; j < m; j++)
					if (need_m[i*MAX_RES+j] > work[j]) fits = 1'b0;
				if (fits) begin
					for (int j = 0; j < m; j++) begin
						w = 32'(work[j]) + 32'(alloc_m[i*MAX_RES+j]);
						work[j] = (w > WORK_MAX) ? WORK_MAX : w[12:0];
					end
					fin[i] = 1'b1;
					done++;
					prog = 1'b1;
				end
			end
			if (!prog) return 1'b0;
		end
		return 1'b1;
	endfunction

	// expected status of one item, updating the predictor state
	function automatic logic [2:0] predict_status(input item_t it);
		int unsigned n, m, k;
		n = procs_used();
		m = res_used();
		k = it.pid * MAX_RES + it.rid;
		case (it.kind)
			T_LOAD_PROC: begin
				if (it.rid >= MAX_RES) return ST_BADIDX;
				alloc_m[k] = it.a;
				if (it.b >= it.a) begin
					need_m[k] = it.b - it.a;
					return ST_LOADED;
				end
				need_m[k] = '0;
				return ST_CLAIMLOW;
			end
			T_LOAD_AVAIL: begin
				if (it.rid >= MAX_RES) return ST_BADIDX;
				avail_m[it.rid] = it.a;
				return ST_LOADED;
			end
			T_REQUEST: begin
				if (it.pid >= n) return ST_BADIDX;
				for (int j = 0; j < m; j++)
					if (it.rq[j] > need_m[it.pid*MAX_RES+j]) return ST_EXCEEDS;
				for (int j = 0; j < m; j++)
					if (it.rq[j] > avail_m[j]) return ST_WAIT;
				for (int j = 0; j < m; j++) begin
					avail_m[j] -= it.rq[j];
					alloc_m[it.pid*MAX_RES+j] += it.rq[j];
					need_m[it.pid*MAX_RES+j] -= it.rq[j];
				end
				if (all_can_finish(n, m)) return ST_GRANTED;
				for (int j = 0; j < m; j++) begin
					avail_m[j] += it.rq[j];
					alloc_m[it.pid*MAX_RES+j] -= it.rq[j];
					need_m[it.pid*MAX_RES+j] += it.rq[j];
				end
				return ST_UNSAFE;
			end
			default: return ST_BADIDX;
		endcase
	endfunction

	// one input transfer; valid stays high for a back-to-back follower
	task automatic send_item(input item_t it);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_type <= it.kind;
		process_id <= it.pid;
		resource_id <= it.rid;
		first_value <= it.a;
		second_value <= it.b;
		req_0 <= it.rq[0];
		req_1 <= it.rq[1];
		req_2 <= it.rq[2];
		req_3 <= it.rq[3];
		req_4 <= it.rq[4];
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		status_q.push_back(predict_status(it));
	endtask

	// register write once every result is back
	task automatic write_cfg(input logic [2:0] idx, input logic [4:0] val);
		in_valid <= 1'b0;
		while (status_q.size() != 0) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == CFG_NPROC) nproc_reg = 32'(val);
		else if (idx == CFG_NRES) nres_reg = 32'(val[2:0]);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic item_t mk(input logic [1:0] kind, input logic [3:0] pid,
			input logic [2:0] rid, input logic [7:0] a, input logic [7:0] b);
		item_t it;
		it.kind = kind;
		it.pid = pid;
		it.rid = rid;
		it.a = a;
		it.b = b;
		for (int j = 0; j < MAX_RES; j++) it.rq[j] = '0;
		return it;
	endfunction

	function automatic item_t mk_req(input logic [3:0] pid, input logic [7:0] r0,
			input logic [7:0] r1, input logic [7:0] r2, input logic [7:0] r3,
			input logic [7:0] r4);
		item_t it;
		it = mk(T_REQUEST, pid, 3'd0, 8'd0, 8'd0);
		it.rq[0] = r0;
		it.rq[1] = r1;
		it.rq[2] = r2;
		it.rq[3] = r3;
		it.rq[4] = r4;
		return it;
	endfunction

	// every row and available count gets a value before any request
	task automatic test_fill_stores();
		for (int p = 0; p < MAX_PROCS; p++)
			for (int r = 0; r < MAX_RES; r++)
				send_item(mk(T_LOAD_PROC, 4'(p), 3'(r), 8'($urandom_range(0, 3)),
					8'($urandom_range(3, 9))));
		for (int r = 0; r < MAX_RES; r++)
			send_item(mk(T_LOAD_AVAIL, 4'd0, 3'(r), 8'($urandom_range(4, 12)), 8'd0));
	endtask

	task automatic test_directed();
		write_cfg(CFG_NPROC, 5'd2);
		write_cfg(CFG_NRES, 3'd1);
		send_item(mk(T_LOAD_PROC, 0, 0, 8'd0, 8'd4));
		send_item(mk(T_LOAD_PROC, 1, 0, 8'd0, 8'd4));
		send_item(mk(T_LOAD_AVAIL, 0, 0, 8'd2, 8'd0));
		// unsafe: nobody can finish after the grant
		send_item(mk_req(0, 8'd2, 8'd255, 8'd255, 8'd255, 8'd255));
		send_item(mk_req(0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0));
		send_item(mk_req(0, 8'd5, 8'd0, 8'd0, 8'd0, 8'd0));
		send_item(mk_req(1, 8'd3, 8'd0, 8'd0, 8'd0, 8'd0));
		send_item(mk_req(2, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
		send_item(mk_req(15, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
		// claim below allocation, field extremes
		send_item(mk(T_LOAD_PROC, 1, 0, 8'd10, 8'd5));
		send_item(mk(T_LOAD_PROC, 15, 4, 8'd255, 8'd255));
		send_item(mk(T_LOAD_PROC, 15, 4, 8'd255, 8'd0));
		send_item(mk(T_LOAD_PROC, 3, 5, 8'd1, 8'd2));
		send_item(mk(T_LOAD_PROC, 3, 7, 8'd1, 8'd2));
		send_item(mk(T_LOAD_AVAIL, 0, 7, 8'd255, 8'd255));
		send_item(mk(T_LOAD_AVAIL, 0, 4, 8'd255, 8'd0));
		send_item(mk(T_UNKNOWN, 4'hf, 3'd7, 8'hff, 8'hff));
		send_item(mk(T_LOAD_PROC, 1, 0, 8'd1, 8'd3));
		send_item(mk_req(1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
		send_item(mk(T_LOAD_AVAIL, 0, 0, 8'd0, 8'd0));
		send_item(mk_req(1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0));
	endtask

	function automatic item_t rand_item(input int unsigned n);
		item_t it;
		int sel;
		sel = $urandom_range(0, 99);
		it = mk(T_REQUEST, 0, 0, 0, 0);
		if (sel < 55) begin
			it.pid = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
					: 4'($urandom_range(0, n - 1));
			for (int j = 0; j < MAX_RES; j++)
				it.rq[j] = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
						: 8'($urandom_range(0, 3));
		end else if (sel < 80) begin
			it.kind = T_LOAD_PROC;
			it.pid = 4'($urandom_range(0, n - 1));
			it.rid = 3'($urandom_range(0, MAX_RES - 1));
			it.a = 8'($urandom_range(0, 6));
			it.b = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 5))
					: 8'(it.a + 8'($urandom_range(0, 8)));
		end else if (sel < 94) begin
			it.kind = T_LOAD_AVAIL;
			it.rid = 3'($urandom_range(0, MAX_RES - 1));
			it.a = 8'($urandom_range(0, 20));
		end else begin
			// noise across all field bits
			it.kind = 2'($urandom_range(0, 3));
			it.pid = 4'($urandom_range(0, 15));
			it.rid = 3'($urandom_range(0, 7));
			it.a = 8'($urandom_range(0, 255));
			it.b = 8'($urandom_range(0, 255));
			for (int j = 0; j < MAX_RES; j++) it.rq[j] = 8'($urandom_range(0, 255));
		end
		return it;
	endfunction

	task automatic test_random_phase(input logic [4:0] np, input logic [2:0] nr, input int count);
		write_cfg(CFG_NPROC, np);
		write_cfg(CFG_NRES, {2'b00, nr});
		for (int i = 0; i < count; i++) send_item(rand_item(procs_used()));
	endtask

	task automatic test_random();
		test_random_phase(5'd16, 3'd5, 200);
		test_random_phase(5'd31, 3'd7, 150);
		test_random_phase(5'd0, 3'd0, 150);
		test_random_phase(5'd1, 3'd5, 150);
		for (int p = 0; p < 5; p++)
			test_random_phase(5'($urandom_range(2, 8)), 3'($urandom_range(1, 5)), 200);
	endtask

	task automatic test_no_idle();
		calm = 1'b1;
		test_random_phase(5'd4, 3'd3, 150);
	endtask

	// result checking and output stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (status_q.size() == 0)
					report_mismatch($sformatf("unexpected status %0d", status));
				else if (status !== status_q[0]) begin
					report_mismatch($sformatf("status %0d, expected %0d", status, status_q[0]));
					void'(status_q.pop_front());
				end else
					void'(status_q.pop_front());
			end
			if (calm) out_ready <= 1'b1;
			else if (out_stall > 0) begin
				out_stall <= out_stall - 1;
				out_ready <= (out_stall == 1);
			end else if ($urandom_range(0, 5) == 0) begin
				out_stall <= $urandom_range(1, 6);
				out_ready <= 1'b0;
			end else
				out_ready <= 1'b1;
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_stores();
		test_directed();
		test_random();
		test_no_idle();
		in_valid <= 1'b0;
		while (status_q.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		if (errors == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

endmodule
